// File: src/aepi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aepi_pkg;

    // Field widths.
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned EST_W   = 24;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned TICKS_W = 7;
    localparam int unsigned INTEG_W = 32;

    // Shared multiplier operand and product widths.
    localparam int unsigned MUL_A_W = 33;
    localparam int unsigned MUL_B_W = 18;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // Estimator constants: 0.2 m in Q4.12 and the no-sample timeout.
    localparam logic [DIST_W-1:0]  ACCEPT_WINDOW = 16'd819;
    localparam logic [TICKS_W-1:0] RESET_TICKS   = 7'd71;

    // floor(x / 3) == (x * DIV3_RECIP) >> DIV3_SHIFT for any 16-bit x.
    localparam logic [MUL_B_W-1:0] DIV3_RECIP = 18'd43691;
    localparam int unsigned        DIV3_SHIFT = 17;

    // Configuration reset values.
    localparam logic [15:0] RST_FILTER_WEIGHT  = 16'd6554;
    localparam logic [15:0] RST_TICK_PERIOD    = 16'd917;
    localparam logic [9:0]  RST_TICK_RATE      = 10'd70;
    localparam logic [15:0] RST_POSITION_GAIN  = 16'd256;
    localparam logic [15:0] RST_VELOCITY_GAIN  = 16'd256;
    localparam logic [15:0] RST_INTEGRAL_GAIN  = 16'd256;
    localparam logic [15:0] RST_SPEED_LIMIT    = 16'd4096;
    localparam logic [14:0] RST_THROTTLE_LIMIT = 15'd1000;

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0] {
        CFG_FILTER_WEIGHT  = 3'd0,
        CFG_TICK_PERIOD    = 3'd1,
        CFG_TICK_RATE      = 3'd2,
        CFG_POSITION_GAIN  = 3'd3,
        CFG_VELOCITY_GAIN  = 3'd4,
        CFG_INTEGRAL_GAIN  = 3'd5,
        CFG_SPEED_LIMIT    = 3'd6,
        CFG_THROTTLE_LIMIT = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] filter_weight;
        logic [15:0] tick_period;
        logic [9:0]  tick_rate;
        logic [15:0] position_gain;
        logic [15:0] velocity_gain;
        logic [15:0] integral_gain;
        logic [15:0] speed_limit;
        logic [14:0] throttle_limit;
    } cfg_t;

    // Datapath step commands issued by the sequencer.
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_LOAD,
        STEP_INST,
        STEP_FILT_A,
        STEP_FILT_B,
        STEP_EST,
        STEP_EXT,
        STEP_EXT_W,
        STEP_ERR,
        STEP_KX,
        STEP_KI,
        STEP_INC1,
        STEP_DT,
        STEP_INT,
        STEP_VEL,
        STEP_OUT
    } step_t;

endpackage

`default_nettype wire

// File: src/aepi_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module aepi_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [aepi_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [aepi_pkg::CFG_W-1:0]   cfg_wdata,
    output aepi_pkg::cfg_t                    cfg
);
    import aepi_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and mask the data to the register width.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_FILTER_WEIGHT:  cfg_next.filter_weight  = cfg_wdata;
                CFG_TICK_PERIOD:    cfg_next.tick_period    = cfg_wdata;
                CFG_TICK_RATE:      cfg_next.tick_rate      = cfg_wdata[9:0];
                CFG_POSITION_GAIN:  cfg_next.position_gain  = cfg_wdata;
                CFG_VELOCITY_GAIN:  cfg_next.velocity_gain  = cfg_wdata;
                CFG_INTEGRAL_GAIN:  cfg_next.integral_gain  = cfg_wdata;
                CFG_SPEED_LIMIT:    cfg_next.speed_limit    = cfg_wdata;
                CFG_THROTTLE_LIMIT: cfg_next.throttle_limit = cfg_wdata[14:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_weight  <= RST_FILTER_WEIGHT;
            cfg_reg.tick_period    <= RST_TICK_PERIOD;
            cfg_reg.tick_rate      <= RST_TICK_RATE;
            cfg_reg.position_gain  <= RST_POSITION_GAIN;
            cfg_reg.velocity_gain  <= RST_VELOCITY_GAIN;
            cfg_reg.integral_gain  <= RST_INTEGRAL_GAIN;
            cfg_reg.speed_limit    <= RST_SPEED_LIMIT;
            cfg_reg.throttle_limit <= RST_THROTTLE_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/aepi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module aepi_ctrl (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output aepi_pkg::step_t step
);
    import aepi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INST,
        ST_FILT_A,
        ST_FILT_B,
        ST_EST,
        ST_EXT,
        ST_EXT_W,
        ST_ERR,
        ST_KX,
        ST_KI,
        ST_INC1,
        ST_DT,
        ST_INT,
        ST_VEL,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // Sequence the datapath steps; the result register frees when its result is taken.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        step         = STEP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    step       = STEP_LOAD;
                    state_next = ST_INST;
                end
            end
            ST_INST: begin
                step       = STEP_INST;
                state_next = ST_FILT_A;
            end
            ST_FILT_A: begin
                step       = STEP_FILT_A;
                state_next = ST_FILT_B;
            end
            ST_FILT_B: begin
                step       = STEP_FILT_B;
                state_next = ST_EST;
            end
            ST_EST: begin
                step       = STEP_EST;
                state_next = ST_EXT;
            end
            ST_EXT: begin
                step       = STEP_EXT;
                state_next = ST_EXT_W;
            end
            ST_EXT_W: begin
                step       = STEP_EXT_W;
                state_next = ST_ERR;
            end
            ST_ERR: begin
                step       = STEP_ERR;
                state_next = ST_KX;
            end
            ST_KX: begin
                step       = STEP_KX;
                state_next = ST_KI;
            end
            ST_KI: begin
                step       = STEP_KI;
                state_next = ST_INC1;
            end
            ST_INC1: begin
                step       = STEP_INC1;
                state_next = ST_DT;
            end
            ST_DT: begin
                step       = STEP_DT;
                state_next = ST_INT;
            end
            ST_INT: begin
                step       = STEP_INT;
                state_next = ST_VEL;
            end
            ST_VEL: begin
                step       = STEP_VEL;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold here until the result register is free.
                if (!m_valid_reg || m_ready) begin
                    step         = STEP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: src/aepi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module aepi_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire aepi_pkg::step_t              step,
    input  wire aepi_pkg::cfg_t               cfg,
    input  wire logic [aepi_pkg::DIST_W-1:0]  in_ground_distance,
    input  wire logic [aepi_pkg::DIST_W-1:0]  in_setpoint,
    input  wire logic                         in_clear_integrator,
    output logic signed [aepi_pkg::THR_W-1:0] out_throttle,
    output logic signed [aepi_pkg::EST_W-1:0] out_height,
    output logic signed [aepi_pkg::EST_W-1:0] out_speed,
    output logic                              out_fire
);
    import aepi_pkg::*;

    // Saturate a 26-bit signed value to the 24-bit estimate range.
    function automatic logic signed [EST_W-1:0] sat24(input logic signed [25:0] x);
        logic signed [EST_W-1:0] r;
        if (x > 26'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (x < -26'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = x[EST_W-1:0];
        end
        return r;
    endfunction

    // Estimator and integrator state.
    logic signed [EST_W-1:0]   height_reg, height_next;
    logic signed [EST_W-1:0]   speed_reg, speed_next;
    logic [DIST_W-1:0]         last_reg, last_next;
    logic [TICKS_W-1:0]        ticks_reg, ticks_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic                      fired_reg, fired_next;

    // Working registers of one item.
    logic [DIST_W-1:0]         gd_reg, gd_next;
    logic [DIST_W-1:0]         sp_reg, sp_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [20:0]        inst_reg, inst_next;
    logic signed [41:0]        acc_reg, acc_next;
    logic signed [24:0]        err_reg, err_next;
    logic [14:0]               ilim_reg, ilim_next;
    logic signed [16:0]        vd_reg, vd_next;
    logic signed [MUL_A_W-1:0] inc1_reg, inc1_next;
    logic signed [25:0]        dv_reg, dv_next;

    // Result register.
    logic signed [THR_W-1:0]   out_thr_reg, out_thr_next;
    logic signed [EST_W-1:0]   out_h_reg, out_h_next;
    logic signed [EST_W-1:0]   out_v_reg, out_v_next;
    logic                      out_fire_reg, out_fire_next;

    // Shared multiplier operands.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    // Intermediate arithmetic.
    logic signed [16:0]        diff;
    logic                      accept;
    logic [TICKS_W-1:0]        ticks_inc;
    logic signed [41:0]        filt_sum;
    logic signed [41:0]        filt_tmp;
    logic signed [40:0]        ext_tmp;
    logic signed [25:0]        h_sum;
    logic signed [41:0]        kx_tmp;
    logic signed [33:0]        kx_rnd;
    logic signed [33:0]        lim_s;
    logic signed [41:0]        ki_tmp;
    logic signed [49:0]        int_tmp;
    logic signed [38:0]        isum;
    logic signed [38:0]        ilim_s;
    logic signed [43:0]        total;
    logic signed [43:0]        total_adj;
    logic signed [23:0]        thr_q;
    logic signed [23:0]        thr_lim;

    // Sample acceptance window against the last accepted sample.
    assign diff      = $signed({1'b0, gd_reg}) - $signed({1'b0, last_reg});
    assign accept    = (diff <= $signed({1'b0, ACCEPT_WINDOW}))
                    && (diff >= -$signed({1'b0, ACCEPT_WINDOW}));
    assign ticks_inc = ticks_reg + 7'd1;

    // Filter: ((65536-k)*v + k*inst + half) >> 16.
    assign filt_sum = acc_reg + $signed(prod_reg[41:0]);
    assign filt_tmp = filt_sum + 42'sd32768;

    // Extrapolation: h + round(v*DT >> 16).
    assign ext_tmp = $signed(prod_reg[40:0]) + 41'sd32768;
    assign h_sum   = 26'(height_reg) + 26'($signed(ext_tmp[40:16]));

    // Desired speed, rounded and limited.
    assign kx_tmp = $signed(prod_reg[41:0]) + 42'sd128;
    assign kx_rnd = kx_tmp[41:8];
    assign lim_s  = $signed({18'd0, cfg.speed_limit});

    // Integrator increment stages.
    assign ki_tmp  = $signed(prod_reg[41:0]) + 42'sd128;
    assign int_tmp = $signed(prod_reg[49:0]) + 50'sd2048;
    assign isum    = 39'(integ_reg) + 39'($signed(int_tmp[49:12]));
    assign ilim_s  = $signed({8'd0, ilim_reg, 16'd0});

    // Throttle: truncate toward zero, then saturate.
    assign total     = $signed(prod_reg[43:0])
                     + $signed({{8{integ_reg[INTEG_W-1]}}, integ_reg, 4'd0});
    assign total_adj = total[43] ? (total + 44'sd1048575) : total;
    assign thr_q     = total_adj[43:20];
    assign thr_lim   = $signed({9'd0, cfg.throttle_limit});

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step)
            STEP_INST: begin
                mul_a = MUL_A_W'(diff);
                mul_b = $signed({8'd0, cfg.tick_rate});
            end
            STEP_FILT_A: begin
                mul_a = MUL_A_W'(speed_reg);
                mul_b = $signed({1'b0, 17'h10000 - {1'b0, cfg.filter_weight}});
            end
            STEP_FILT_B: begin
                mul_a = MUL_A_W'(inst_reg);
                mul_b = $signed({2'd0, cfg.filter_weight});
            end
            STEP_EXT: begin
                mul_a = MUL_A_W'(speed_reg);
                mul_b = $signed({2'd0, cfg.tick_period});
            end
            STEP_ERR: begin
                mul_a = $signed({17'd0, cfg.throttle_limit, 1'b0});
                mul_b = $signed(DIV3_RECIP);
            end
            STEP_KX: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed({2'd0, cfg.position_gain});
            end
            STEP_KI: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed({2'd0, cfg.integral_gain});
            end
            STEP_DT: begin
                mul_a = inc1_reg;
                mul_b = $signed({2'd0, cfg.tick_period});
            end
            STEP_VEL: begin
                mul_a = MUL_A_W'(dv_reg);
                mul_b = $signed({2'd0, cfg.velocity_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Step decode and register updates.
    always_comb begin
        height_next   = height_reg;
        speed_next    = speed_reg;
        last_next     = last_reg;
        ticks_next    = ticks_reg;
        integ_next    = integ_reg;
        fired_next    = fired_reg;
        gd_next       = gd_reg;
        sp_next       = sp_reg;
        // The product holds while no step runs, so a stalled last step still sees it.
        prod_next     = (step == STEP_NONE) ? prod_reg
                                            : PROD_W'(mul_a) * PROD_W'(mul_b);
        inst_next     = inst_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        ilim_next     = ilim_reg;
        vd_next       = vd_reg;
        inc1_next     = inc1_reg;
        dv_next       = dv_reg;
        out_thr_next  = out_thr_reg;
        out_h_next    = out_h_reg;
        out_v_next    = out_v_reg;
        out_fire_next = out_fire_reg;
        case (step)
            STEP_LOAD: begin
                gd_next = in_ground_distance;
                sp_next = in_setpoint;
                if (in_clear_integrator) begin
                    integ_next = '0;
                end
            end
            STEP_FILT_A: begin
                inst_next = prod_reg[20:0];
            end
            STEP_FILT_B: begin
                acc_next = prod_reg[41:0];
            end
            STEP_EST: begin
                // Accepted sample, timeout reset, or plain tick count.
                if (accept) begin
                    speed_next  = sat24(filt_tmp[41:16]);
                    height_next = $signed({8'd0, gd_reg});
                    last_next   = gd_reg;
                    ticks_next  = '0;
                    fired_next  = 1'b0;
                end else if (ticks_inc >= RESET_TICKS) begin
                    speed_next  = '0;
                    height_next = $signed({8'd0, gd_reg});
                    last_next   = gd_reg;
                    ticks_next  = '0;
                    fired_next  = 1'b1;
                end else begin
                    ticks_next  = ticks_inc;
                    fired_next  = 1'b0;
                end
            end
            STEP_EXT_W: begin
                if (!fired_reg) begin
                    height_next = sat24(h_sum);
                end
            end
            STEP_ERR: begin
                err_next = $signed({9'd0, sp_reg}) - 25'(height_reg);
            end
            STEP_KX: begin
                ilim_next = prod_reg[DIV3_SHIFT+14:DIV3_SHIFT];
            end
            STEP_KI: begin
                if (kx_rnd > lim_s) begin
                    vd_next = 17'(lim_s);
                end else if (kx_rnd < -lim_s) begin
                    vd_next = 17'(-lim_s);
                end else begin
                    vd_next = kx_rnd[16:0];
                end
            end
            STEP_INC1: begin
                inc1_next = ki_tmp[40:8];
            end
            STEP_INT: begin
                if (isum > ilim_s) begin
                    integ_next = INTEG_W'(ilim_s);
                end else if (isum < -ilim_s) begin
                    integ_next = INTEG_W'(-ilim_s);
                end else begin
                    integ_next = isum[INTEG_W-1:0];
                end
                dv_next = 26'(vd_reg) - 26'(speed_reg);
            end
            STEP_OUT: begin
                if (thr_q > thr_lim) begin
                    out_thr_next = thr_lim[THR_W-1:0];
                end else if (thr_q < -thr_lim) begin
                    out_thr_next = 16'(-thr_lim);
                end else begin
                    out_thr_next = thr_q[THR_W-1:0];
                end
                out_h_next    = height_reg;
                out_v_next    = speed_reg;
                out_fire_next = fired_reg;
            end
            default: begin
                gd_next = gd_reg;
            end
        endcase
    end

    // Estimator and integrator state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= '0;
            speed_reg  <= '0;
            last_reg   <= '0;
            ticks_reg  <= '0;
            integ_reg  <= '0;
            fired_reg  <= 1'b0;
        end else begin
            height_reg <= height_next;
            speed_reg  <= speed_next;
            last_reg   <= last_next;
            ticks_reg  <= ticks_next;
            integ_reg  <= integ_next;
            fired_reg  <= fired_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge aclk) begin
        gd_reg       <= gd_next;
        sp_reg       <= sp_next;
        prod_reg     <= prod_next;
        inst_reg     <= inst_next;
        acc_reg      <= acc_next;
        err_reg      <= err_next;
        ilim_reg     <= ilim_next;
        vd_reg       <= vd_next;
        inc1_reg     <= inc1_next;
        dv_reg       <= dv_next;
        out_thr_reg  <= out_thr_next;
        out_h_reg    <= out_h_next;
        out_v_reg    <= out_v_next;
        out_fire_reg <= out_fire_next;
    end

    assign out_throttle = out_thr_reg;
    assign out_height   = out_h_reg;
    assign out_speed    = out_v_reg;
    assign out_fire     = out_fire_reg;

endmodule

`default_nettype wire

// File: src/altitude_estimator_and_pi_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    ground_distance, setpoint, clear_integrator
// m_        out        m_valid / m_ready    throttle_out, estimated_height,
//                                           estimated_speed, estimate_reset
// cfg_      in         cfg_wr_en            cfg_index, cfg_wdata (write only)
//
// A request is loaded at its accepting edge and its result is registered after 14
// further sequencer steps, most of them sharing a single 33x18 signed multiplier.
// A new request is accepted in the cycle after the result is registered.
// The result register holds while m_ready is low; the next request still runs and
// waits at its last step until that register is free.
// Reset (aresetn, synchronous, active low) restores register defaults and zeroes the
// estimator and integrator state.

module altitude_estimator_and_pi_controller (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [aepi_pkg::DIST_W-1:0]   s_ground_distance,
    input  wire logic [aepi_pkg::DIST_W-1:0]   s_setpoint,
    input  wire logic                          s_clear_integrator,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [aepi_pkg::THR_W-1:0]  m_throttle_out,
    output logic signed [aepi_pkg::EST_W-1:0]  m_estimated_height,
    output logic signed [aepi_pkg::EST_W-1:0]  m_estimated_speed,
    output logic                               m_estimate_reset,
    input  wire logic                          cfg_wr_en,
    input  wire logic [aepi_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [aepi_pkg::CFG_W-1:0]    cfg_wdata
);
    import aepi_pkg::*;

    cfg_t  cfg;
    step_t step;

    // Configuration registers.
    aepi_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Step sequencer and handshake control.
    aepi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .step    (step)
    );

    // Estimator and controller arithmetic.
    aepi_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .step                (step),
        .cfg                 (cfg),
        .in_ground_distance  (s_ground_distance),
        .in_setpoint         (s_setpoint),
        .in_clear_integrator (s_clear_integrator),
        .out_throttle        (m_throttle_out),
        .out_height          (m_estimated_height),
        .out_speed           (m_estimated_speed),
        .out_fire            (m_estimate_reset)
    );

endmodule

`default_nettype wire

// File: tb/altitude_estimator_and_pi_controller_test.sv
`timescale 1ns / 1ps

module altitude_estimator_and_pi_controller_test;
    import aepi_pkg::*;

    localparam int  CYCLE_LIMIT = 500000;
    localparam int  PHASE_COUNT = 6;
    localparam int  PHASE_TICKS = 142;
    localparam longint HEIGHT_MAX = 64'sd8388607;
    localparam longint HEIGHT_MIN = -64'sd8388608;

    // One result of a control tick, as the block reports it.
    typedef struct packed {
        logic signed [THR_W-1:0] throttle;
        logic signed [EST_W-1:0] height;
        logic signed [EST_W-1:0] speed;
        logic                    fired;
    } tick_result_t;

    // Tracks the estimator and controller state and the results still owed.
    class throttle_scoreboard;
        longint filter_weight, tick_period, tick_rate, position_gain;
        longint velocity_gain, integral_gain, speed_limit, throttle_limit;
        longint height, speed, integrator;
        int     last_sample, ticks;
        int     errors;
        tick_result_t pending_ticks[$];

        function new();
            filter_weight  = RST_FILTER_WEIGHT;
            tick_period    = RST_TICK_PERIOD;
            tick_rate      = RST_TICK_RATE;
            position_gain  = RST_POSITION_GAIN;
            velocity_gain  = RST_VELOCITY_GAIN;
            integral_gain  = RST_INTEGRAL_GAIN;
            speed_limit    = RST_SPEED_LIMIT;
            throttle_limit = RST_THROTTLE_LIMIT;
            height = 0;
            speed = 0;
            integrator = 0;
            last_sample = 0;
            ticks = 0;
            errors = 0;
        endfunction

        function longint round_shift(longint x, int s);
            return (x + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint trunc_shift(longint x, int s);
            if (x >= 0) begin
                return x >>> s;
            end
            return -((-x) >>> s);
        endfunction

        function longint limit(longint x, longint lo, longint hi);
            if (x < lo) begin
                return lo;
            end
            if (x > hi) begin
                return hi;
            end
            return x;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_FILTER_WEIGHT:  filter_weight  = val;
                CFG_TICK_PERIOD:    tick_period    = val;
                CFG_TICK_RATE:      tick_rate      = val[9:0];
                CFG_POSITION_GAIN:  position_gain  = val;
                CFG_VELOCITY_GAIN:  velocity_gain  = val;
                CFG_INTEGRAL_GAIN:  integral_gain  = val;
                CFG_SPEED_LIMIT:    speed_limit    = val;
                CFG_THROTTLE_LIMIT: throttle_limit = val[14:0];
                default: ;
            endcase
        endfunction

        // Advances the model by one accepted request and queues its result.
        function void predict_tick(logic [DIST_W-1:0] gd, logic [DIST_W-1:0] sp, logic clr);
            longint diff, err, vd, inc, ilim, total, thr;
            tick_result_t r;
            r.fired = 1'b0;
            ticks = (ticks + 1) & 8'h7f;
            diff = longint'(gd) - longint'(last_sample);

            // A sample close to the last accepted one updates the speed filter.
            if (diff <= longint'(ACCEPT_WINDOW) && diff >= -longint'(ACCEPT_WINDOW)) begin
                speed = round_shift((65536 - filter_weight) * speed
                                    + filter_weight * (diff * tick_rate), 16);
                speed = limit(speed, HEIGHT_MIN, HEIGHT_MAX);
                height = gd;
                last_sample = gd;
                ticks = 0;
            end

            // Too long without a usable sample restarts the estimate.
            if (ticks >= int'(RESET_TICKS)) begin
                speed = 0;
                height = gd;
                last_sample = gd;
                ticks = 0;
                r.fired = 1'b1;
            end else begin
                height = limit(height + round_shift(speed * tick_period, 16),
                               HEIGHT_MIN, HEIGHT_MAX);
            end

            // Cascade controller.
            if (clr) begin
                integrator = 0;
            end
            err = longint'(sp) - height;
            vd = limit(round_shift(position_gain * err, 8), -speed_limit, speed_limit);
            inc = round_shift(round_shift(integral_gain * err, 8) * tick_period, 12);
            ilim = ((throttle_limit * 2) / 3) * 65536;
            integrator = limit(integrator + inc, -ilim, ilim);
            total = velocity_gain * (vd - speed) + integrator * 16;
            thr = limit(trunc_shift(total, 20), -throttle_limit, throttle_limit);

            r.throttle = thr[THR_W-1:0];
            r.height = height[EST_W-1:0];
            r.speed = speed[EST_W-1:0];
            pending_ticks.push_back(r);
        endfunction

        function void compare_tick(tick_result_t act);
            tick_result_t exp_r;
            if (pending_ticks.size() == 0) begin
                $display("%0t: unexpected result, throttle_out %0d", $time, act.throttle);
                errors++;
                return;
            end
            exp_r = pending_ticks.pop_front();
            if (act.throttle !== exp_r.throttle) begin
                $display("%0t: throttle_out expected %0d, got %0d",
                         $time, exp_r.throttle, act.throttle);
                errors++;
            end
            if (act.height !== exp_r.height) begin
                $display("%0t: estimated_height expected %0d, got %0d",
                         $time, exp_r.height, act.height);
                errors++;
            end
            if (act.speed !== exp_r.speed) begin
                $display("%0t: estimated_speed expected %0d, got %0d",
                         $time, exp_r.speed, act.speed);
                errors++;
            end
            if (act.fired !== exp_r.fired) begin
                $display("%0t: estimate_reset expected %0b, got %0b",
                         $time, exp_r.fired, act.fired);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [DIST_W-1:0]        s_ground_distance;
    logic [DIST_W-1:0]        s_setpoint;
    logic                     s_clear_integrator;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [THR_W-1:0]  m_throttle_out;
    logic signed [EST_W-1:0]  m_estimated_height;
    logic signed [EST_W-1:0]  m_estimated_speed;
    logic                     m_estimate_reset;
    logic                     cfg_wr_en;
    logic [CIDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]         cfg_wdata;

    throttle_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cycles;
    bit  ramp_up;

    altitude_estimator_and_pi_controller u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_ground_distance  (s_ground_distance),
        .s_setpoint         (s_setpoint),
        .s_clear_integrator (s_clear_integrator),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_throttle_out     (m_throttle_out),
        .m_estimated_height (m_estimated_height),
        .m_estimated_speed  (m_estimated_speed),
        .m_estimate_reset   (m_estimate_reset),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The receiver stalls at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Every accepted result is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.compare_tick({m_throttle_out, m_estimated_height,
                             m_estimated_speed, m_estimate_reset});
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Issues one request; entered and left at a falling edge, valid left high.
    task automatic send_request(logic [DIST_W-1:0] gd, logic [DIST_W-1:0] sp, logic clr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ground_distance <= gd;
        s_setpoint <= sp;
        s_clear_integrator <= clr;
        do @(posedge aclk); while (!s_ready);
        sb.predict_tick(gd, sp, clr);
        @(negedge aclk);
    endtask

    // Builds a request around the last accepted sample: a usable one or an outlier.
    task automatic send_random_tick(bit outlier);
        int last, delta, gd, sp, pick;
        last = sb.last_sample;
        if (outlier) begin
            gd = (last + 820 + $urandom_range(0, 63896)) % 65536;
        end else begin
            pick = $urandom_range(0, 99);
            if (last > 62000) begin
                ramp_up = 1'b0;
            end
            if (last < 3000) begin
                ramp_up = 1'b1;
            end
            if (pick < 40) begin
                delta = int'($urandom_range(0, 1638)) - 819;
            end else if (pick < 80) begin
                delta = int'($urandom_range(600, 819));
                if (!ramp_up) begin
                    delta = -delta;
                end
            end else if (pick < 96) begin
                delta = $urandom_range(0, 1) ? 819 : -819;
            end else begin
                delta = $urandom_range(0, 1) ? 820 : -820;
            end
            gd = last + delta;
            if (gd < 0) begin
                gd = 0;
            end
            if (gd > 65535) begin
                gd = 65535;
            end
        end
        if ($urandom_range(0, 1)) begin
            sp = last + int'($urandom_range(0, 4095)) - 2048;
            if (sp < 0) begin
                sp = 0;
            end
            if (sp > 65535) begin
                sp = 65535;
            end
        end else begin
            sp = $urandom_range(0, 65535);
        end
        send_request(gd[DIST_W-1:0], sp[DIST_W-1:0], ($urandom_range(0, 15) == 0));
    endtask

    // Waits until every predicted result has come back.
    task automatic wait_drained();
        while (sb.pending_ticks.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_register(idx, val);
        @(negedge aclk);
    endtask

    // Writes every register for one phase of the run.
    task automatic apply_settings(int phase);
        logic [CFG_W-1:0] v [8];
        case (phase)
            0: begin
                v[0] = 16'($urandom);
                v[1] = 16'($urandom_range(1, 4000));
                v[2] = 16'($urandom_range(1, 1000));
                v[3] = 16'($urandom_range(0, 2048));
                v[4] = 16'($urandom_range(0, 2048));
                v[5] = 16'($urandom_range(0, 2048));
                v[6] = 16'($urandom_range(0, 16384));
                v[7] = 16'($urandom_range(1, 32767));
            end
            1: begin
                foreach (v[i]) v[i] = 16'hffff;
            end
            2: begin
                foreach (v[i]) v[i] = '0;
            end
            3: begin
                foreach (v[i]) v[i] = 16'($urandom);
            end
            4: begin
                v[0] = 16'hffff;
                v[1] = 16'hffff;
                v[2] = 16'd1000;
                v[3] = 16'd4096;
                v[4] = 16'd64;
                v[5] = 16'd1024;
                v[6] = 16'hffff;
                v[7] = 16'd32767;
            end
            default: begin
                v[0] = RST_FILTER_WEIGHT;
                v[1] = RST_TICK_PERIOD;
                v[2] = CFG_W'(RST_TICK_RATE);
                v[3] = RST_POSITION_GAIN;
                v[4] = RST_VELOCITY_GAIN;
                v[5] = RST_INTEGRAL_GAIN;
                v[6] = RST_SPEED_LIMIT;
                v[7] = CFG_W'(RST_THROTTLE_LIMIT);
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            write_reg(cfg_index_t'(i), v[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                send_idle_pct = 25;
                recv_stall_pct = 69;
            end
            1: begin
                send_idle_pct = 69;
                recv_stall_pct = 25;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    initial begin
        int burst_at, burst_len;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_ground_distance = '0;
        s_setpoint = '0;
        s_clear_integrator = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        ramp_up = 1'b1;
        sb = new();
        set_idling(0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests on the reset settings: window edges, outliers,
        // a climbing ramp, integrator clears and field extremes.
        send_request(16'd0, 16'd0, 1'b1);
        send_request(16'd819, 16'hffff, 1'b0);
        send_request(16'd1639, 16'd0, 1'b0);
        send_request(16'd0, 16'hffff, 1'b0);
        send_request(16'd820, 16'h8000, 1'b0);
        send_request(16'hffff, 16'hffff, 1'b1);
        send_request(16'd0, 16'hffff, 1'b0);
        send_request(16'd400, 16'hffff, 1'b0);
        send_request(16'd800, 16'hffff, 1'b0);
        send_request(16'd1200, 16'hffff, 1'b0);
        send_request(16'd1600, 16'hffff, 1'b0);
        send_request(16'd2400, 16'hffff, 1'b0);
        send_request(16'd1600, 16'd0, 1'b1);
        send_request(16'd1600, 16'd0, 1'b0);
        send_request(16'd1600, 16'd0, 1'b0);
        send_request(16'haaaa, 16'h5555, 1'b1);
        send_request(16'h5555, 16'haaaa, 1'b0);
        send_request(16'd1600, 16'h0fff, 1'b0);
        s_valid <= 1'b0;

        // Random phases, each with its own settings; pairs of phases share an idling pattern.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_drained();
            apply_settings(phase);
            set_idling(phase / 2);
            burst_at = $urandom_range(10, PHASE_TICKS - 80);
            if (phase == 0 || phase == 3 || phase == 4) begin
                burst_len = $urandom_range(71, 76);
            end else begin
                burst_len = $urandom_range(8, 20);
            end
            for (int n = 0; n < PHASE_TICKS; n++) begin
                send_random_tick((n >= burst_at && n < burst_at + burst_len)
                                 || ($urandom_range(0, 99) < 8));
            end
            s_valid <= 1'b0;
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_ticks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
src/aepi_pkg.sv
src/aepi_cfg_regs.sv
src/aepi_ctrl.sv
src/aepi_datapath.sv
src/altitude_estimator_and_pi_controller.sv
tb/altitude_estimator_and_pi_controller_test.sv
